/* sv/mcrc_pkg.sv */
// Shared types, mode codes and CRC table generator functions for the
// multi-mode CRC byte engine. No dependencies.

package mcrc_pkg;

    // Table mode codes as written to the configuration register
    localparam logic [2:0] MODE_CRC8_ATM    = 3'd0;
    localparam logic [2:0] MODE_CRC16_ANSI  = 3'd1;
    localparam logic [2:0] MODE_CRC16_CCITT = 3'd2;
    localparam logic [2:0] MODE_CRC32_IEEE  = 3'd3;
    localparam logic [2:0] MODE_CRC32_REFL  = 3'd4;
    localparam int         MODE_COUNT       = 5;

    localparam logic [2:0] MODE_RESET = MODE_CRC32_REFL;

    localparam logic [31:0] POLY8_ATM    = 32'h0000_0007;
    localparam logic [31:0] POLY16_ANSI  = 32'h0000_8005;
    localparam logic [31:0] POLY16_CCITT = 32'h0000_1021;
    localparam logic [31:0] POLY32_IEEE  = 32'h04C1_1DB7;
    localparam logic [31:0] POLY32_REFL  = 32'hEDB8_8320;

    // One input request as held in the input register
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [31:0] seed;
    } item_t;

    function automatic logic [31:0] swap16(input logic [31:0] v);
        return {16'd0, v[7:0], v[15:8]};
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // MSB-first table entry for a CRC of the given width
    function automatic logic [31:0] msb_entry(input logic [7:0] idx, input int width,
                                              input logic [31:0] poly);
        logic [31:0] mask;
        logic [31:0] top;
        logic [31:0] v;
        mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
        top  = 32'd1 << (width - 1);
        v    = {24'd0, idx} << (width - 8);
        for (int k = 0; k < 8; k++) begin
            if ((v & top) != 32'd0) begin
                v = ((v << 1) ^ poly) & mask;
            end else begin
                v = (v << 1) & mask;
            end
        end
        return v;
    endfunction

    // LSB-first (reflected) table entry
    function automatic logic [31:0] lsb_entry(input logic [7:0] idx,
                                              input logic [31:0] poly);
        logic [31:0] v;
        v = {24'd0, idx};
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ poly;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

    // Table entry for one mode; evaluated at elaboration only
    function automatic logic [31:0] table_entry(input logic [2:0] mode,
                                                input logic [7:0] idx);
        logic [31:0] e;
        case (mode)
            MODE_CRC8_ATM:    e = msb_entry(idx, 8, POLY8_ATM);
            MODE_CRC16_ANSI:  e = swap16(msb_entry(idx, 16, POLY16_ANSI));
            MODE_CRC16_CCITT: e = swap16(msb_entry(idx, 16, POLY16_CCITT));
            MODE_CRC32_IEEE:  e = swap32(msb_entry(idx, 32, POLY32_IEEE));
            default:          e = lsb_entry(idx, POLY32_REFL);
        endcase
        return e;
    endfunction

endpackage

/* sv/mcrc_table.sv */
// Byte-wide CRC table lookup for all five modes.
// Depends on mcrc_pkg. Each table is linear in its index, so an entry is the
// xor of the eight single-bit entries selected by the index bits.

module mcrc_table (
    input  logic [2:0]  mode,
    input  logic [7:0]  index,
    output logic [31:0] entry
);
    import mcrc_pkg::*;

    logic [31:0] basis      [MODE_COUNT][8];
    logic [31:0] mode_entry [MODE_COUNT];

    for (genvar m = 0; m < MODE_COUNT; m++) begin : g_mode
        for (genvar b = 0; b < 8; b++) begin : g_bit
            localparam logic [31:0] BASIS_ENTRY = table_entry(3'(m), 8'(1 << b));
            assign basis[m][b] = BASIS_ENTRY;
        end
    end

    always_comb begin
        for (int m = 0; m < MODE_COUNT; m++) begin
            mode_entry[m] = 32'd0;
            for (int b = 0; b < 8; b++) begin
                if (index[b]) begin
                    mode_entry[m] = mode_entry[m] ^ basis[m][b];
                end
            end
        end
    end

    always_comb begin
        case (mode)
            MODE_CRC8_ATM:    entry = mode_entry[0];
            MODE_CRC16_ANSI:  entry = mode_entry[1];
            MODE_CRC16_CCITT: entry = mode_entry[2];
            MODE_CRC32_IEEE:  entry = mode_entry[3];
            MODE_CRC32_REFL:  entry = mode_entry[4];
            default:          entry = 32'd0;
        endcase
    end

endmodule

/* sv/mcrc_core.sv */
// Fold stage: running CRC register, one table step per request, and the
// result register. Depends on mcrc_pkg and mcrc_table.

module mcrc_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [2:0]         mode,
    input  logic               item_valid,
    input  mcrc_pkg::item_t    item,
    output logic               item_take,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        out_crc,
    output logic               out_last,
    output logic               out_bad
);
    import mcrc_pkg::*;

    logic [31:0] running_crc_reg;
    logic [31:0] running_crc_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_crc_reg;
    logic        out_last_reg;
    logic        out_bad_reg;

    logic        bad;
    logic [31:0] start_crc;
    logic [31:0] entry;
    logic [31:0] fold_crc;

    assign bad       = (mode >= 3'(MODE_COUNT));
    assign start_crc = item.first_byte ? item.seed : running_crc_reg;

    mcrc_table u_table (
        .mode  (mode),
        .index (start_crc[7:0] ^ item.data_byte),
        .entry (entry)
    );

    assign fold_crc  = entry ^ {8'd0, start_crc[31:8]};
    assign item_take = item_valid && (!out_valid_reg || out_ready);

    always_comb begin
        running_crc_next = running_crc_reg;
        out_valid_next   = out_valid_reg;
        if (item_take) begin
            out_valid_next = 1'b1;
            // leave the register alone on an invalid mode
            if (!bad) begin
                running_crc_next = fold_crc;
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_crc_reg <= 32'd0;
            out_valid_reg   <= 1'b0;
        end else begin
            running_crc_reg <= running_crc_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take) begin
            out_crc_reg  <= bad ? 32'd0 : fold_crc;
            out_last_reg <= item.last_byte;
            out_bad_reg  <= bad;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_crc   = out_crc_reg;
    assign out_last  = out_last_reg;
    assign out_bad   = out_bad_reg;

    a_take_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        item_take |=> out_valid_reg)
        else $error("taken request did not reach the result register");

    a_good_result_is_state: assert property (@(posedge aclk) disable iff (!aresetn)
        item_take && !bad |=> running_crc_reg == out_crc_reg)
        else $error("result differs from running crc");

    a_bad_mode_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        item_take && bad |=> $stable(running_crc_reg) && out_bad_reg && out_crc_reg == 32'd0)
        else $error("invalid mode changed state or gave nonzero crc");

    a_idle_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !item_take |=> $stable(running_crc_reg))
        else $error("running crc changed without a request");

endmodule

/* sv/multi_mode_crc_byte_engine.sv */
// Top level of the multi-mode CRC byte engine: input register, mode register
// and the fold stage. Depends on mcrc_pkg and mcrc_core.
//
//  channel | direction | contents
//  s_      | in        | tdata {seed, data_byte}, tuser first_byte, tlast last_byte
//  m_      | out       | tdata crc_value, tuser bad_mode, tlast run_done
//  cfg_    | in        | cfg_data crc_mode, always ready
//
// One request per cycle sustained while m_tready is high; a request passes
// through the input register and then, via the table step, into the result
// register, from which it is presented on m_.
// The running CRC feeds back through one table lookup and xor per taken request.
// Reset clears the running CRC to zero and sets crc_mode to 4.
// A stalled m_ side holds its result; s_tready drops only when both the input
// register and the result register are full.

module multi_mode_crc_byte_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] data_byte, [39:8] seed
    input  logic        s_tuser,   // [0] first_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] crc_value
    output logic        m_tuser,   // [0] bad_mode
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data
);
    import mcrc_pkg::*;

    logic [2:0] mode_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    item_t      in_item_reg;
    logic       item_take;
    logic       s_accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RESET;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    assign s_tready = !in_valid_reg || item_take;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (item_take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.data_byte  <= s_tdata[7:0];
            in_item_reg.seed       <= s_tdata[39:8];
            in_item_reg.first_byte <= s_tuser;
            in_item_reg.last_byte  <= s_tlast;
        end
    end

    mcrc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .mode       (mode_reg),
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .item_take  (item_take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_crc    (m_tdata),
        .out_last   (m_tlast),
        .out_bad    (m_tuser)
    );

endmodule
